// ===== hdl/lpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the lidar point curvature block: sizes, register codes and
// the command and status structs between controller and datapath. No dependencies.
package lpc_pkg;
	localparam int NPOINTS = 64;
	localparam int IDX_W = $clog2(NPOINTS);
	localparam int CNT_W = $clog2(NPOINTS + 1);
	localparam int COORD_W = 24;
	localparam int SUM_W = 30;
	localparam int V_W = COORD_W + CNT_W + 1;
	localparam int SQ_W = 2 * V_W + 2;
	localparam int RT_W = SQ_W / 2;
	localparam int DEN_W = 38;
	localparam int NUM_W = RT_W + 24;
	localparam int Q_W = 32;
	localparam logic [15:0] MIN_DEN_RESET = 16'd66;
	localparam logic [0:0] REG_MIN_DEN = 1'b0;

	typedef struct packed {
		logic load;
		logic clear;
		logic rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic calc_start;
	} lpc_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic calc_done;
	} lpc_sts_t;
endpackage

// ===== hdl/lpc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the lidar point curvature block: point stores, running sums and
// iterative square root and divider units. Depends on lpc_pkg.
module lpc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  lpc_pkg::lpc_cmd_t cmd,
	output lpc_pkg::lpc_sts_t sts,
	input  logic signed [lpc_pkg::COORD_W-1:0] x_coord,
	input  logic signed [lpc_pkg::COORD_W-1:0] y_coord,
	input  logic signed [lpc_pkg::COORD_W-1:0] z_coord,
	input  logic [15:0] min_den,
	output logic [lpc_pkg::Q_W-1:0] smooth,
	output logic clamped
);
	localparam int CW = lpc_pkg::COORD_W;
	localparam int VW = lpc_pkg::V_W;
	localparam int SW = lpc_pkg::SQ_W;
	localparam int RW = lpc_pkg::RT_W;
	localparam int NW = lpc_pkg::NUM_W;
	localparam int DW = lpc_pkg::DEN_W;
	localparam int NW_CNT = $clog2(NW + 1);

	typedef enum logic [2:0] {P_IDLE, P_SQ, P_ACC, P_ROOT, P_DEN, P_DIV, P_FIN} ph_t;

	logic [CW-1:0] mem_x [lpc_pkg::NPOINTS];
	logic [CW-1:0] mem_y [lpc_pkg::NPOINTS];
	logic [CW-1:0] mem_z [lpc_pkg::NPOINTS];
	logic signed [CW-1:0] rx_q, ry_q, rz_q;
	logic signed [lpc_pkg::SUM_W-1:0] sx_q, sy_q, sz_q;
	logic [lpc_pkg::CNT_W-1:0] cnt_q;

	ph_t ph_q;
	logic [1:0] ax_q;
	logic signed [VW-1:0] v_q;
	logic signed [CW-1:0] p_q;
	logic [SW-1:0] vacc_q, pacc_q;
	logic [SW-1:0] ra_q, rb_q;
	logic [SW-1:0] rva_q, rvb_q;
	logic [5:0] rstep_q;
	logic [NW-1:0] num_q, quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW_CNT-1:0] dstep_q;
	logic done_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_x[cnt_q[lpc_pkg::IDX_W-1:0]] <= x_coord;
			mem_y[cnt_q[lpc_pkg::IDX_W-1:0]] <= y_coord;
			mem_z[cnt_q[lpc_pkg::IDX_W-1:0]] <= z_coord;
		end
		if (cmd.rd_en) begin
			rx_q <= mem_x[cmd.rd_idx];
			ry_q <= mem_y[cmd.rd_idx];
			rz_q <= mem_z[cmd.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			cnt_q <= '0;
		end else if (cmd.clear) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			sx_q <= sx_q + lpc_pkg::SUM_W'(x_coord);
			sy_q <= sy_q + lpc_pkg::SUM_W'(y_coord);
			sz_q <= sz_q + lpc_pkg::SUM_W'(z_coord);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	logic signed [CW-1:0] pc;
	logic signed [lpc_pkg::SUM_W-1:0] sc;
	logic signed [VW-1:0] vmul;
	logic [VW-1:0] vabs;
	logic [CW-1:0] pabs;
	logic [2*VW-1:0] vsq;
	logic [2*CW-1:0] psq;
	always_comb begin
		case (ax_q)
			2'd0: begin pc = rx_q; sc = sx_q; end
			2'd1: begin pc = ry_q; sc = sy_q; end
			default: begin pc = rz_q; sc = sz_q; end
		endcase
		vmul = VW'(pc) * $signed({1'b0, cnt_q}) - VW'(sc);
		vabs = v_q[VW-1] ? VW'(-v_q) : VW'(v_q);
		pabs = p_q[CW-1] ? CW'(-p_q) : CW'(p_q);
		vsq = vabs * vabs;
		psq = pabs * pabs;
	end

	logic [SW-1:0] rta, rtb;
	logic [SW-1:0] rra, rrb;
	logic [SW-1:0] bitv;
	logic [SW-1:0] ta, tb;
	always_comb begin
		bitv = SW'(1) << (SW - 2 - 2 * rstep_q);
		ta = rva_q + bitv;
		tb = rvb_q + bitv;
		if (ra_q >= ta) begin
			rta = ra_q - ta;
			rra = (rva_q >> 1) + bitv;
		end else begin
			rta = ra_q;
			rra = rva_q >> 1;
		end
		if (rb_q >= tb) begin
			rtb = rb_q - tb;
			rrb = (rvb_q >> 1) + bitv;
		end else begin
			rtb = rb_q;
			rrb = rvb_q >> 1;
		end
	end

	logic [DW:0] rsh;
	logic [DW-1:0] mden;
	always_comb begin
		rsh = {rem_q[DW-1:0], num_q[NW-1]};
		mden = (min_den == 16'd0) ? DW'(1) : DW'(min_den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			done_q <= 1'b0;
			ax_q <= '0;
			rstep_q <= '0;
			dstep_q <= '0;
		end else begin
			case (ph_q)
				P_IDLE: begin
					if (cmd.calc_start) begin
						ph_q <= P_SQ;
						done_q <= 1'b0;
						ax_q <= '0;
						vacc_q <= '0;
						pacc_q <= '0;
					end
				end
				P_SQ: begin
					v_q <= vmul;
					p_q <= pc;
					ph_q <= P_ACC;
				end
				P_ACC: begin
					vacc_q <= vacc_q + SW'(vsq);
					pacc_q <= pacc_q + SW'(psq);
					if (ax_q == 2'd2) begin
						ph_q <= P_ROOT;
						ra_q <= vacc_q + SW'(vsq);
						rb_q <= pacc_q + SW'(psq);
						rva_q <= '0;
						rvb_q <= '0;
						rstep_q <= '0;
					end else begin
						ax_q <= ax_q + 2'd1;
						ph_q <= P_SQ;
					end
				end
				P_ROOT: begin
					ra_q <= rta;
					rb_q <= rtb;
					rva_q <= rra;
					rvb_q <= rrb;
					rstep_q <= rstep_q + 6'd1;
					if (rstep_q == 6'(SW / 2 - 1))
						ph_q <= P_DEN;
				end
				P_DEN: begin
					den_q <= DW'({rvb_q[RW-1:0] * cnt_q, 8'd0});
					ph_q <= P_DIV;
				end
				P_DIV: begin
					if (dstep_q == '0) begin
						if (den_q < mden) begin
							den_q <= mden;
							clamped <= 1'b1;
						end else begin
							clamped <= 1'b0;
						end
						num_q <= NW'(rva_q) << 24;
						rem_q <= '0;
						quo_q <= '0;
						dstep_q <= dstep_q + 1'b1;
					end else begin
						num_q <= num_q << 1;
						if (rsh >= {1'b0, den_q}) begin
							rem_q <= rsh - {1'b0, den_q};
							quo_q <= {quo_q[NW-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							quo_q <= {quo_q[NW-2:0], 1'b0};
						end
						if (dstep_q == NW_CNT'(NW)) begin
							dstep_q <= '0;
							ph_q <= P_FIN;
						end else begin
							dstep_q <= dstep_q + 1'b1;
						end
					end
				end
				P_FIN: begin
					smooth <= (|quo_q[NW-1:lpc_pkg::Q_W]) ? '1 : quo_q[lpc_pkg::Q_W-1:0];
					done_q <= 1'b1;
					ph_q <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign sts.count = cnt_q;
	assign sts.calc_done = done_q;
endmodule

// ===== hdl/lpc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the lidar point curvature block: load phase, per-point
// computation sequencing and output register. Depends on lpc_pkg.
module lpc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_last,
	output lpc_pkg::lpc_cmd_t cmd,
	input  lpc_pkg::lpc_sts_t sts,
	input  logic [lpc_pkg::Q_W-1:0] smooth,
	input  logic clamped,
	output logic out_valid,
	input  logic out_ready,
	output logic [lpc_pkg::IDX_W+lpc_pkg::Q_W+1:0] out_data
);
	typedef enum logic [2:0] {S_LOAD, S_READ, S_CALC, S_OUT, S_CLEAR} st_t;

	st_t st_q;
	logic [lpc_pkg::IDX_W-1:0] k_q;
	logic [lpc_pkg::CNT_W-1:0] n_q;
	logic acc;
	logic fits;

	assign in_ready = (st_q == S_LOAD);
	assign acc = in_valid && in_ready;
	assign fits = sts.count < lpc_pkg::CNT_W'(lpc_pkg::NPOINTS);

	always_comb begin
		cmd.load = acc && fits;
		cmd.clear = (st_q == S_CLEAR);
		cmd.rd_en = (st_q == S_READ);
		cmd.rd_idx = k_q;
		cmd.calc_start = (st_q == S_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			k_q <= '0;
			n_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			case (st_q)
				S_LOAD: begin
					if (acc && in_last) begin
						k_q <= '0;
						n_q <= fits ? sts.count + 1'b1 : sts.count;
						st_q <= S_READ;
					end
				end
				S_READ: begin
					if (out_valid && out_ready)
						out_valid <= 1'b0;
					st_q <= S_CALC;
				end
				S_CALC: begin
					if (sts.calc_done && (!out_valid || out_ready)) begin
						out_valid <= 1'b1;
						out_data <= {(lpc_pkg::CNT_W'(k_q) + 1'b1 == n_q), clamped, smooth, k_q};
						if (lpc_pkg::CNT_W'(k_q) + 1'b1 == n_q) begin
							st_q <= S_CLEAR;
						end else begin
							k_q <= k_q + 1'b1;
							st_q <= S_READ;
						end
					end else if (out_valid && out_ready) begin
						out_valid <= 1'b0;
					end
				end
				S_CLEAR: begin
					if (out_valid && out_ready)
						out_valid <= 1'b0;
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b0;
						st_q <= S_LOAD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ===== hdl/lidar_point_curvature.sv =====
`timescale 1ns / 1ps
// Top level of the lidar point curvature block: APB register, controller and
// datapath. Depends on lpc_pkg, lpc_ctrl and lpc_datapath.
// Points are taken one per cycle while a set loads. After the point marked
// tlast each stored point is processed in turn: the squared terms are formed
// axis by axis, two 33-step square roots run side by side, the denominator is
// formed, a restoring divider takes one setup and 57 steps, and the result is
// finished, handed to the output and the next point read.
// A result held by a stalled output delays the next point by that stall. After
// the final result the controller passes its clear and output states, and that
// result must be taken, before the next set is accepted.
module lidar_point_curvature (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [71:0] s_tdata,  // x_coord, y_coord, z_coord
	input  logic s_tlast,         // last_point
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,  // point_index, smoothness, clamped, zero fill
	output logic m_tlast,         // last_result
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	lpc_pkg::lpc_cmd_t cmd;
	lpc_pkg::lpc_sts_t sts;
	logic [15:0] min_den_q;
	logic [lpc_pkg::Q_W-1:0] smooth;
	logic clamped;
	logic [lpc_pkg::IDX_W+lpc_pkg::Q_W+1:0] od;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_den_q <= lpc_pkg::MIN_DEN_RESET;
		else if (psel && penable && pwrite && paddr[1:0] == {lpc_pkg::REG_MIN_DEN, 1'b0})
			min_den_q <= pwdata[15:0];
	end
	assign prdata = (paddr == {lpc_pkg::REG_MIN_DEN, 1'b0}) ? {16'd0, min_den_q} : 32'd0;

	lpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_last(s_tlast), .cmd(cmd), .sts(sts), .smooth(smooth), .clamped(clamped),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
	);

	lpc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.x_coord(s_tdata[23:0]), .y_coord(s_tdata[47:24]), .z_coord(s_tdata[71:48]),
		.min_den(min_den_q), .smooth(smooth), .clamped(clamped)
	);

	assign m_tdata = {1'b0, od[lpc_pkg::IDX_W+lpc_pkg::Q_W:0]};
	assign m_tlast = od[lpc_pkg::IDX_W+lpc_pkg::Q_W+1];
endmodule

// ===== hdl/lpc_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the lidar point curvature block, bound to the top level.
// Depends on lidar_point_curvature only through its ports.
module lpc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic [39:0] m_tdata,
	input logic pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable({m_tlast, m_tdata}))
		else $error("output moved");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during output");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && $past(s_tready) |-> m_tdata[5:0] == 6'd0)
		else $error("first result index");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind lidar_point_curvature lpc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tlast(m_tlast), .m_tdata(m_tdata), .pready(pready)
);

// ===== bench/lidar_point_curvature_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lidar_point_curvature: a directed table and random point sets,
// checked against predicted results (index, smoothness, clamp, last). Depends on lpc_pkg and the RTL.
module lidar_point_curvature_tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 256;

	typedef logic signed [lpc_pkg::COORD_W-1:0] coord_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic last;
		logic typed;
		logic [31:0] smooth;
		logic clamp;
	} point_row_t;

	typedef struct {
		logic [lpc_pkg::IDX_W-1:0] idx;
		logic [31:0] smooth;
		logic clamp;
		logic last;
	} curv_res_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [71:0] s_tdata;  // x_coord, y_coord, z_coord
	logic s_tlast;         // last_point
	logic m_tvalid;
	logic m_tready;
	logic [39:0] m_tdata;  // point_index, smoothness, clamped, zero fill
	logic m_tlast;         // last_result
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lidar_point_curvature i_dut (.*);

	coord_t pts_x[lpc_pkg::NPOINTS];
	coord_t pts_y[lpc_pkg::NPOINTS];
	coord_t pts_z[lpc_pkg::NPOINTS];
	longint sum_px, sum_py, sum_pz;
	int n_stored;
	logic [15:0] min_den;
	curv_res_t curv_q[$];
	int errors = 0;
	int sets_closed = 0;
	int results_seen = 0;
	int clamped_seen = 0;
	int points_sent = 0;
	bit quiet_in = 0;
	bit quiet_out = 0;

	localparam coord_t CMAX = 24'sh7FFFFF;
	localparam coord_t CMIN = -24'sh800000;

	point_row_t directed[] = '{
		'{24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b1, 32'd0, 1'b1},
		'{24'sd1, 24'sd0, 24'sd0, 1'b1, 1'b1, 32'd0, 1'b0},
		'{CMAX, CMAX, CMAX, 1'b1, 1'b1, 32'd0, 1'b0},
		'{CMIN, CMIN, CMIN, 1'b1, 1'b1, 32'd0, 1'b0},
		'{CMAX, 24'sd0, 24'sd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CMIN, 24'sd0, 24'sd0, 1'b1, 1'b0, 32'd0, 1'b0},
		'{-24'sd1, -24'sd1, -24'sd1, 1'b0, 1'b0, 32'd0, 1'b0},
		'{24'sh123456, -24'sd5, 24'sd7, 1'b0, 1'b0, 32'd0, 1'b0},
		'{24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0, 32'd0, 1'b0},
		'{CMAX, CMIN, 24'sd3, 1'b0, 1'b0, 32'd0, 1'b0},
		'{CMIN, CMAX, -24'sd3, 1'b0, 1'b0, 32'd0, 1'b0},
		'{24'sh555555, -24'sh2AAAAA, 24'sd256, 1'b0, 1'b0, 32'd0, 1'b0},
		'{24'sd1, 24'sd1, 24'sd0, 1'b1, 1'b0, 32'd0, 1'b0},
		'{24'sd2, 24'sd0, 24'sd0, 1'b0, 1'b0, 32'd0, 1'b0},
		'{24'sd0, 24'sd2, 24'sd0, 1'b1, 1'b0, 32'd0, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic longint unsigned int_sqrt(input longint unsigned a);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a)
			b >>= 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sq(input longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		return m * m;
	endfunction

	// Updates the point store and, when a set closes, queues its curvature results.
	task automatic predict_curvature(input coord_t x, input coord_t y, input coord_t z,
			input logic last);
		longint vx, vy, vz;
		longint unsigned vnorm, pnorm, den, q, md;
		curv_res_t r;
		if (n_stored < lpc_pkg::NPOINTS) begin
			pts_x[n_stored] = x;
			pts_y[n_stored] = y;
			pts_z[n_stored] = z;
			sum_px += x;
			sum_py += y;
			sum_pz += z;
			n_stored++;
		end
		if (!last)
			return;
		md = (min_den == 0) ? 1 : min_den;
		for (int k = 0; k < n_stored; k++) begin
			vx = n_stored * longint'(pts_x[k]) - sum_px;
			vy = n_stored * longint'(pts_y[k]) - sum_py;
			vz = n_stored * longint'(pts_z[k]) - sum_pz;
			vnorm = int_sqrt(sq(vx) + sq(vy) + sq(vz));
			pnorm = int_sqrt(sq(pts_x[k]) + sq(pts_y[k]) + sq(pts_z[k]));
			den = longint'(n_stored) * pnorm * 256;
			r.clamp = 1'b0;
			if (den < md) begin
				den = md;
				r.clamp = 1'b1;
			end
			q = (vnorm << 24) / den;
			r.smooth = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			r.idx = k[lpc_pkg::IDX_W-1:0];
			r.last = (k + 1 == n_stored);
			curv_q = {curv_q, r};
		end
		sum_px = 0;
		sum_py = 0;
		sum_pz = 0;
		n_stored = 0;
		sets_closed++;
	endtask

	task automatic send_point(input coord_t x, input coord_t y, input coord_t z, input logic last,
			input logic typed, input logic [31:0] smooth, input logic clamp);
		int gap;
		if ($urandom_range(0, 19) == 0)
			quiet_in = !quiet_in;
		gap = quiet_in ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		points_sent++;
		predict_curvature(x, y, z, last);
		if (typed) begin
			curv_q[curv_q.size() - 1].smooth = smooth;
			curv_q[curv_q.size() - 1].clamp = clamp;
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (curv_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_den(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(4 * lpc_pkg::REG_MIN_DEN);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		min_den = value[15:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata != {16'd0, min_den})
			report($sformatf("register read %h, wrote %h", prdata, value));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic coord_t rand_coord(input int kind);
		case (kind)
			0: return coord_t'($urandom());
			1: return coord_t'($urandom_range(0, 6)) - 24'sd3;
			2: return 24'sd0;
			default: return $urandom_range(0, 1) ? CMAX : CMIN;
		endcase
	endfunction

	task automatic send_random_set(input int len);
		int kind;
		for (int i = 0; i < len; i++) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 5) ? 0 : (kind < 8) ? 1 : (kind < 9) ? 2 : 3;
			send_point(rand_coord(kind), rand_coord(kind), rand_coord(kind), i == len - 1,
				1'b0, 32'd0, 1'b0);
		end
	endtask

	task automatic random_phase(input int items, input bit overflow);
		int sent;
		int len;
		sent = 0;
		if (overflow) begin
			len = $urandom_range(lpc_pkg::NPOINTS + 1, lpc_pkg::NPOINTS + 6);
			send_random_set(len);
			sent += len;
		end
		while (sent < items) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			send_random_set(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sum_px = 0;
		sum_py = 0;
		sum_pz = 0;
		n_stored = 0;
		min_den = lpc_pkg::MIN_DEN_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
				directed[i].typed, directed[i].smooth, directed[i].clamp);
		wait_idle();
		write_min_den(32'd1);
		random_phase(RANDOM_ITEMS / 4, 1'b1);
		wait_idle();
		write_min_den(32'hFFFF_FFFF);
		random_phase(RANDOM_ITEMS / 4, 1'b0);
		wait_idle();
		write_min_den(32'h1234_0000);
		random_phase(RANDOM_ITEMS / 4, 1'b1);
		wait_idle();
		write_min_den($urandom());
		random_phase(RANDOM_ITEMS / 4, 1'b0);
		wait_idle();
		$display("%0d points in %0d sets, %0d results checked (%0d clamped).",
			points_sent, sets_closed, results_seen, clamped_seen);
		$display("Clamp settings covered: reset value, 1, 65535, zero and a random value.");
		if (errors == 0)
			$display("lidar_point_curvature_tb: PASS");
		else
			$display("lidar_point_curvature_tb: FAIL");
		$finish;
	end

	initial begin
		curv_res_t e;
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				quiet_out = !quiet_out;
			stall = quiet_out ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			results_seen++;
			if (m_tdata[38])
				clamped_seen++;
			if (curv_q.size() == 0) begin
				report($sformatf("unexpected result %h", m_tdata));
			end else begin
				e = curv_q.pop_front();
				if (m_tdata[5:0] != e.idx)
					report($sformatf("point_index %0d, expected %0d", m_tdata[5:0], e.idx));
				if (m_tdata[37:6] != e.smooth)
					report($sformatf("smoothness %h, expected %h (index %0d)",
						m_tdata[37:6], e.smooth, e.idx));
				if (m_tdata[38] != e.clamp)
					report($sformatf("clamped %b, expected %b (index %0d)",
						m_tdata[38], e.clamp, e.idx));
				if (m_tlast != e.last)
					report($sformatf("last_result %b, expected %b (index %0d)",
						m_tlast, e.last, e.idx));
			end
			@(posedge clk);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timed out with %0d results outstanding.", curv_q.size());
				$display("lidar_point_curvature_tb: FAIL");
				$finish;
			end
		end
	end
endmodule
